>>> hdl/swks_pkg.sv
// shared types and constants for the sliding window k-smallest sum block
package swks_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_OUT_W = 22;
    localparam int CFG_W = 7;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 8'd1;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 7'd64;
    localparam logic [CFG_W-1:0] KEEP_COUNT_RST = 7'd1;

    typedef struct packed {
        logic start;
        logic remove;
        logic insert;
    } swks_cmd_t;

    typedef struct packed {
        logic full;
        logic out_due;
    } swks_status_t;

endpackage

>>> hdl/swks_ram.sv
// generic single port ram with registered read
module swks_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hdl/swks_ctrl.sv
// controller state machine for the sliding window k-smallest sum block
module swks_ctrl
    import swks_pkg::*;
#(
    parameter int LVL = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  swks_status_t status,
    output swks_cmd_t    cmd
);

    localparam int LC_W = $clog2(LVL + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REMOVE = 3'd1;
    localparam logic [2:0] ST_INSERT = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [LC_W-1:0] lvl_cnt_reg, lvl_cnt_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        lvl_cnt_next = lvl_cnt_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start = 1'b1;
                    state_next = status.full ? ST_REMOVE : ST_INSERT;
                end
            end
            ST_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                lvl_cnt_next = '0;
                state_next = status.out_due ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                // one adder tree level settles per cycle
                lvl_cnt_next = lvl_cnt_reg + 1'b1;
                if (lvl_cnt_reg == LC_W'(LVL - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lvl_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_cnt_reg <= lvl_cnt_next;
        end
    end

    a_remove_then_insert: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove |=> cmd.insert)
        else $error("remove not followed by insert");

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

endmodule

>>> hdl/swks_dpath.sv
// datapath: age ram, sorted cell array and registered adder tree
module swks_dpath
    import swks_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_val,
    input  swks_cmd_t            cmd,
    output swks_status_t         status,
    output logic [SUM_OUT_W-1:0] small_sum
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int WW = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int LVL = AW;
    localparam int LEAVES = 1 << LVL;
    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    logic [CFG_W-1:0]       window_len_reg;
    logic [CFG_W-1:0]       keep_count_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [AW-1:0]          wp_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [SAMPLE_BITS-1:0] cell_reg [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_next [WINDOW_MAX];
    logic [SUM_W-1:0]       node_reg [1:LEAVES-1];
    logic [SUM_W-1:0]       leaf [LEAVES];

    logic [WW-1:0]          wl_ext, kc_ext, win_w, keep_w;
    logic [CNT_W-1:0]       win, keep, ins_cnt;
    logic [SAMPLE_BITS-1:0] oldest;
    logic [SAMPLE_BITS+SAMPLE_W-1:0] smp_ext;
    logic [SUM_W+SUM_OUT_W-1:0]      sum_ext;
    logic                   wrap;

    assign wl_ext = WW'(window_len_reg);
    assign kc_ext = WW'(keep_count_reg);
    assign win_w = (wl_ext == '0) ? WW'(1)
                 : (wl_ext > WW'(WINDOW_MAX)) ? WW'(WINDOW_MAX) : wl_ext;
    assign win = win_w[CNT_W-1:0];
    assign keep_w = (kc_ext > win_w) ? win_w : kc_ext;
    assign keep = keep_w[CNT_W-1:0];

    assign smp_ext = {{SAMPLE_BITS{1'b0}}, sample};
    assign status.full = (fill_reg == win);
    assign status.out_due = ((fill_reg + 1'b1) >= win);
    assign wrap = ((CNT_W'(wp_reg) + 1'b1) == win);
    assign ins_cnt = status.full ? (win - 1'b1) : fill_reg;

    swks_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_age_ram (
        .clk   (clk),
        .we    (cmd.insert),
        .addr  (wp_reg),
        .wdata (smp_reg),
        .rdata (oldest)
    );

    // cells shift left to drop the oldest value, shift right to make room
    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        if (cmd.remove)
        begin
            for (int i = 0; i < WINDOW_MAX; i++)
            begin
                if (cell_reg[i] >= oldest)
                begin
                    cell_next[i] = (i == WINDOW_MAX - 1) ? cell_reg[i]
                                 : cell_reg[(i + 1) % WINDOW_MAX];
                end
            end
        end
        else if (cmd.insert)
        begin
            for (int i = 0; i < WINDOW_MAX; i++)
            begin
                if ((CNT_W'(i) >= ins_cnt) || (cell_reg[i] > smp_reg))
                begin
                    if (i == 0)
                    begin
                        cell_next[i] = smp_reg;
                    end
                    else if ((CNT_W'(i - 1) < ins_cnt)
                             && (cell_reg[(i + WINDOW_MAX - 1) % WINDOW_MAX] > smp_reg))
                    begin
                        cell_next[i] = cell_reg[(i + WINDOW_MAX - 1) % WINDOW_MAX];
                    end
                    else
                    begin
                        cell_next[i] = smp_reg;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            leaf[i] = '0;
            if ((i < WINDOW_MAX) && (CNT_W'(i) < keep))
            begin
                leaf[i] = SUM_W'(cell_reg[i % WINDOW_MAX]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        for (int j = 1; j < LEAVES; j++)
        begin
            if (2 * j >= LEAVES)
            begin
                node_reg[j] <= leaf[(2 * j - LEAVES) % LEAVES]
                             + leaf[(2 * j + 1 - LEAVES) % LEAVES];
            end
            else
            begin
                node_reg[j] <= node_reg[(2 * j) % LEAVES] + node_reg[(2 * j + 1) % LEAVES];
            end
        end
        if (cmd.start)
        begin
            smp_reg <= smp_ext[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RST;
            keep_count_reg <= KEEP_COUNT_RST;
            fill_reg <= '0;
            wp_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_WINDOW_LEN:
                begin
                    window_len_reg <= cfg_val;
                    fill_reg <= '0;
                    wp_reg <= '0;
                end
                REG_KEEP_COUNT:
                begin
                    keep_count_reg <= cfg_val;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.insert)
        begin
            wp_reg <= wrap ? '0 : wp_reg + 1'b1;
            if (!status.full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    assign sum_ext = {{SUM_OUT_W{1'b0}}, node_reg[1]};
    assign small_sum = sum_ext[SUM_OUT_W-1:0];

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> fill_reg <= win)
        else $error("fill count beyond window");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> CNT_W'(wp_reg) < win)
        else $error("age pointer beyond window");

    a_fill_full_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && !status.full) |-> CNT_W'(wp_reg) == fill_reg)
        else $error("age pointer out of step with fill count");

endmodule

>>> hdl/sliding_window_k_smallest_sum.sv
// Sliding window sum of the keep_count smallest of the last window_len samples.
// Each sample is taken only when the block is idle. While the window fills a
// sample is captured and then inserted. Once full a sample is captured while the
// oldest is read, then the oldest is removed and the sample inserted. The
// sample that fills the window and every later one then pass through the
// registered adder tree, and the result is held in m_tdata until it is taken.
// No result is given until the window has filled; writing window_len empties it.
module sliding_window_k_smallest_sum
    import swks_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // sample[15:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // small_sum[21:0], zero pad
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    swks_cmd_t            cmd;
    swks_status_t         status;
    logic [SUM_OUT_W-1:0] small_sum;

    assign cfg_ready = 1'b1;
    assign m_tdata = {2'b00, small_sum};

    swks_ctrl #(
        .LVL ($clog2(WINDOW_MAX))
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swks_dpath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_val   (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .small_sum (small_sum)
    );

endmodule

>>> tb/sv/sliding_window_k_smallest_sum_tb.sv
// testbench for the sliding window k-smallest sum block
module sliding_window_k_smallest_sum_tb;
    import swks_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WMAX = 64;
    localparam int SETTLE_CYCLES = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;   // sample[15:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // small_sum[21:0], zero pad
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sliding_window_k_smallest_sum dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [CFG_W-1:0]    win_reg;
    logic [CFG_W-1:0]    keep_reg;
    logic [SAMPLE_W-1:0] age_q[$];     // newest first
    logic [SAMPLE_W-1:0] sorted_q[$];  // ascending
    logic [SUM_OUT_W-1:0] sum_q[$];    // expected sums, oldest first

    int errors = 0;
    int sent = 0;
    int got = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    initial begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    function automatic int eff_window();
        if (win_reg == 0)
            return 1;
        if (win_reg > WMAX)
            return WMAX;
        return int'(win_reg);
    endfunction

    // model the window for one sample, queue the sum if one is due
    function automatic void predict_sum(logic [SAMPLE_W-1:0] v);
        int w;
        int k;
        int pos;
        logic [SUM_OUT_W+1:0] acc;
        w = eff_window();
        while (age_q.size() > w)
            void'(age_q.pop_back());
        if (age_q.size() == w)
        begin
            logic [SAMPLE_W-1:0] old;
            old = age_q.pop_back();
            for (int i = 0; i < sorted_q.size(); i++)
            begin
                if (sorted_q[i] == old)
                begin
                    sorted_q.delete(i);
                    break;
                end
            end
        end
        pos = 0;
        while (pos < sorted_q.size() && sorted_q[pos] <= v)
            pos++;
        sorted_q.insert(pos, v);
        age_q.push_front(v);
        if (age_q.size() < w)
            return;
        k = (keep_reg > w) ? w : int'(keep_reg);
        acc = '0;
        for (int i = 0; i < k; i++)
            acc += sorted_q[i];
        sum_q.push_back(acc[SUM_OUT_W-1:0]);
    endfunction

    // starts and ends at a falling edge; s_tvalid is left high for the next
    // request or dropped by drain
    task automatic send_sample(logic [SAMPLE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_sum(v);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sum_q.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_WINDOW_LEN)
        begin
            win_reg = val;
            age_q.delete();
            sorted_q.delete();
        end
        else if (idx == REG_KEEP_COUNT)
            keep_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got++;
            if (sum_q.size() == 0)
            begin
                $error("small_sum: unexpected result %0d", m_tdata[SUM_OUT_W-1:0]);
                errors++;
            end
            else
            begin
                logic [SUM_OUT_W-1:0] exp_sum;
                exp_sum = sum_q.pop_front();
                if (m_tdata[SUM_OUT_W-1:0] !== exp_sum)
                begin
                    $error("small_sum: expected %0d, got %0d", exp_sum,
                           m_tdata[SUM_OUT_W-1:0]);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic test_directed();
        // default window of 64, keep 1
        for (int i = 0; i < 64; i++)
            send_sample(16'(i * 1000 + 7));
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        // window 1 with keep count zero and above window
        write_reg(REG_WINDOW_LEN, 7'd1);
        write_reg(REG_KEEP_COUNT, 7'd0);
        send_sample(16'hFFFF);
        write_reg(REG_KEEP_COUNT, 7'd5);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        // window length zero behaves as one
        write_reg(REG_WINDOW_LEN, 7'd0);
        send_sample(16'h1234);
        send_sample(16'h8001);
        // window length above max, keep all, largest sum with ties
        write_reg(REG_WINDOW_LEN, 7'd127);
        write_reg(REG_KEEP_COUNT, 7'd127);
        for (int i = 0; i < 66; i++)
            send_sample(16'hFFFF);
        // keep count change mid-window does not empty it
        write_reg(REG_KEEP_COUNT, 7'd64);
        send_sample(16'h0001);
        write_reg(REG_KEEP_COUNT, 7'd3);
        send_sample(16'h0002);
    endtask

    task automatic test_random(int n_items);
        int w;
        w = $urandom_range(9) == 0 ? $urandom_range(64) : $urandom_range(8);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(39) == 0)
            begin
                w = $urandom_range(15) == 0 ? $urandom_range(127) : $urandom_range(10);
                write_reg(REG_WINDOW_LEN, 7'(w));
            end
            if ($urandom_range(29) == 0)
                write_reg(REG_KEEP_COUNT, 7'($urandom_range(12) == 0 ?
                          $urandom_range(127) : $urandom_range(10)));
            // narrow range now and then for ties
            if ($urandom_range(3) == 0)
                send_sample(16'($urandom_range(3)));
            else
                send_sample(16'($urandom));
        end
    endtask

    task automatic test_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(500);
        send_idle_pct = 83; recv_stall_pct = 0;  test_random(400);
        send_idle_pct = 0;  recv_stall_pct = 83; test_random(400);
        send_idle_pct = 12; recv_stall_pct = 12; test_random(450);
    endtask

    initial begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        win_reg = WINDOW_LEN_RST;
        keep_reg = KEEP_COUNT_RST;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_phases();
        drain();
        if (sum_q.size() != 0)
        begin
            $error("small_sum: %0d expected results never arrived", sum_q.size());
            errors++;
        end
        $display("samples sent: %0d, sums checked: %0d, window/keep settings swept",
                 sent, got);
        if (errors == 0)
            $display("sliding_window_k_smallest_sum_tb passed");
        else
            $display("sliding_window_k_smallest_sum_tb failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("sliding_window_k_smallest_sum_tb failed");
        $finish;
    end

endmodule
